>>> rtl/ptu_pkg.sv
// Package: shared types and constants of the particle table update block.
`timescale 1ns / 1ps
package ptu_pkg;

  localparam int unsigned FULL_TURN = 46080;
  localparam logic [23:0] AGE_MAX   = 24'hFFFFFF;

  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // one input word
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_vx;
    logic signed [31:0] start_vy;
    logic        [15:0] start_angle;
    logic signed [15:0] spin_rate;
    logic        [23:0] life_limit;
    logic        [23:0] rgb_color;
    logic signed [31:0] pull_x;
    logic signed [31:0] pull_y;
    logic        [15:0] delta_time;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic        [5:0]  slot;
    logic signed [31:0] now_x;
    logic signed [31:0] now_y;
    logic        [15:0] now_angle;
    logic        [7:0]  alpha;
    logic        [23:0] colour_out;
    logic               last;
    logic               dropped;
  } out_word_t;

  // one table entry
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] pull_x;
    logic [31:0] pull_y;
    logic [15:0] angle;
    logic [15:0] spin;
    logic [23:0] age;
    logic [23:0] limit;
    logic [23:0] colour;
  } rec_t;

endpackage

>>> rtl/ptu_if.sv
// Interfaces: input and result channels of the particle table update block.
`timescale 1ns / 1ps
interface ptu_in_if;
  logic             valid;
  logic             ready;
  ptu_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ptu_out_if;
  logic              valid;
  logic              ready;
  ptu_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/particle_table_update.sv
// Top level: particle table sequencer around the table memory and fade divider.
// Spawn: written in the cycle it is accepted, no result (a drop gives one result in the next cycle).
// Tick: per surviving particle read, check, multiply, add, divide ending in write back,
// emit; per expired one read and check; then a flush, with stalls while the result
// register is full; one tick at a time.
// Results of a tick lag one survivor behind, so the last one can carry last.
// Synchronous active-low reset empties the table; entry contents are not cleared.
`timescale 1ns / 1ps
module particle_table_update #(
  parameter int MAX_PARTICLES = 64
) (
  input  logic clk,
  input  logic rst_n,
  ptu_in_if.sink    in_ch,
  ptu_out_if.source out_ch
);
  import ptu_pkg::*;

  localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PARTICLES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  // fixed result words
  localparam out_word_t LAST_MASK = '{default: '0, last: 1'b1};
  localparam out_word_t DROP_WORD = '{default: '0, last: 1'b1, dropped: 1'b1};

  logic [2:0]    state_r;
  logic [CW-1:0] cnt_r, i_r, w_r;
  logic [15:0]   dt_r;
  rec_t          rec_r;
  logic signed [48:0] px_r, py_r;
  logic signed [32:0] pa_r;
  out_word_t     pend_r, cand_r, out_r;
  logic          pend_v_r, out_v_r;

  logic          accept, wr_en, rd_en, div_start, div_done;
  logic [IW-1:0] wr_addr;
  rec_t          wr_data, rd_data, spawn_rec;
  rec_t          chk_rec, add_rec;
  logic [7:0]    quo;
  logic [24:0]   age_sum;
  logic [23:0]   age_sat;
  logic [16:0]   ang_red;
  logic signed [18:0] ang_s;
  logic [15:0]   ang_new;
  logic          last_i;

  assign in_ch.ready  = (state_r == S_IDLE) && !out_v_r;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // spawn record, start angle reduced below a full turn
  always_comb begin
    ang_red = {1'b0, in_ch.data.start_angle};
    if (ang_red >= 17'(FULL_TURN)) ang_red = ang_red - 17'(FULL_TURN);
    spawn_rec        = '0;
    spawn_rec.pos_x  = in_ch.data.start_x;
    spawn_rec.pos_y  = in_ch.data.start_y;
    spawn_rec.vel_x  = in_ch.data.start_vx;
    spawn_rec.vel_y  = in_ch.data.start_vy;
    spawn_rec.pull_x = in_ch.data.pull_x;
    spawn_rec.pull_y = in_ch.data.pull_y;
    spawn_rec.angle  = ang_red[15:0];
    spawn_rec.spin   = in_ch.data.spin_rate;
    spawn_rec.limit  = in_ch.data.life_limit;
    spawn_rec.colour = in_ch.data.rgb_color;
    spawn_rec.age    = '0;
  end

  // memory write port: spawn append or tick write-back
  always_comb begin
    if (state_r == S_DIV) begin
      wr_en   = div_done;
      wr_addr = w_r[IW-1:0];
      wr_data = rec_r;
    end else begin
      wr_en   = accept && (in_ch.data.opcode == OP_SPAWN) && (cnt_r < MAX_CNT);
      wr_addr = cnt_r[IW-1:0];
      wr_data = spawn_rec;
    end
  end

  assign rd_en = (state_r == S_RD);

  ptu_mem #(.DEPTH(MAX_PARTICLES)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(i_r[IW-1:0]), .rd_data(rd_data)
  );

  // saturating age
  assign age_sum = {1'b0, rd_data.age} + {9'd0, dt_r};
  assign age_sat = age_sum[24] ? AGE_MAX : age_sum[23:0];

  // angle turn with wrap
  always_comb begin
    ang_s = 19'($signed({3'b000, rec_r.angle})) + 19'($signed(pa_r[32:15]));
    if (ang_s < -19'sd46080)      ang_s = ang_s + 19'sd92160;
    else if (ang_s < 19'sd0)      ang_s = ang_s + 19'sd46080;
    else if (ang_s >= 19'sd92160) ang_s = ang_s - 19'sd92160;
    else if (ang_s >= 19'sd46080) ang_s = ang_s - 19'sd46080;
    ang_new = ang_s[15:0];
  end

  // record updates of the check and add stages
  always_comb begin
    chk_rec       = rd_data;
    chk_rec.age   = age_sat;
    chk_rec.vel_x = rd_data.vel_x + rd_data.pull_x;
    chk_rec.vel_y = rd_data.vel_y + rd_data.pull_y;
    add_rec       = rec_r;
    add_rec.pos_x = rec_r.pos_x + px_r[47:16];
    add_rec.pos_y = rec_r.pos_y + py_r[47:16];
    add_rec.angle = ang_new;
  end

  assign div_start = (state_r == S_ADD);
  assign last_i    = (i_r + CW'(1)) >= cnt_r;

  ptu_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(({8'd0, rec_r.age} << 8) - {8'd0, rec_r.age}),
    .den(rec_r.limit), .done(div_done), .quo(quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      i_r      <= '0;
      w_r      <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_v_r && out_ch.ready) out_v_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_ch.data.opcode == OP_SPAWN) begin
              if (cnt_r < MAX_CNT) begin
                cnt_r <= cnt_r + CW'(1);
              end else begin
                out_r   <= DROP_WORD;
                out_v_r <= 1'b1;
              end
            end else begin
              dt_r     <= in_ch.data.delta_time;
              i_r      <= '0;
              w_r      <= '0;
              pend_v_r <= 1'b0;
              state_r  <= (cnt_r == '0) ? S_FLUSH : S_RD;
            end
          end
        end
        S_RD: state_r <= S_CHK;
        S_CHK: begin
          if (age_sat >= rd_data.limit) begin
            i_r     <= i_r + CW'(1);
            state_r <= last_i ? S_FLUSH : S_RD;
          end else begin
            rec_r   <= chk_rec;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          px_r    <= $signed(rec_r.vel_x) * $signed({1'b0, dt_r});
          py_r    <= $signed(rec_r.vel_y) * $signed({1'b0, dt_r});
          pa_r    <= $signed(rec_r.spin) * $signed({1'b0, dt_r});
          state_r <= S_ADD;
        end
        S_ADD: begin
          rec_r   <= add_rec;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            cand_r  <= '{slot: 6'(w_r), now_x: rec_r.pos_x, now_y: rec_r.pos_y,
                         now_angle: rec_r.angle, alpha: 8'd255 - quo,
                         colour_out: rec_r.colour, last: 1'b0, dropped: 1'b0};
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hand the older survivor out, keep the newest pending
          if (!pend_v_r || !out_v_r) begin
            if (pend_v_r) begin
              out_r   <= pend_r;
              out_v_r <= 1'b1;
            end
            pend_r   <= cand_r;
            pend_v_r <= 1'b1;
            w_r      <= w_r + CW'(1);
            i_r      <= i_r + CW'(1);
            state_r  <= last_i ? S_FLUSH : S_RD;
          end
        end
        S_FLUSH: begin
          if (!pend_v_r) begin
            cnt_r   <= w_r;
            state_r <= S_IDLE;
          end else if (!out_v_r) begin
            out_r    <= pend_r | LAST_MASK;
            out_v_r  <= 1'b1;
            pend_v_r <= 1'b0;
            cnt_r    <= w_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT) else $error("particle count above table depth");
  a_wb_behind: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_done) |-> (w_r <= i_r))
    else $error("write-back ahead of read index");
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.dropped) |-> out_r.last)
    else $error("drop word without last");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH && !pend_v_r) |=> (state_r == S_IDLE))
    else $error("flush did not return to idle");
endmodule

>>> rtl/ptu_mem.sv
// Particle table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ptu_mem #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  ptu_pkg::rec_t            wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output ptu_pkg::rec_t            rd_data
);
  import ptu_pkg::*;

  rec_t mem [DEPTH];
  rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

>>> rtl/ptu_div.sv
// Fade divider: 8-bit quotient of num / den, one bit per cycle (needs num < den*256).
`timescale 1ns / 1ps
module ptu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [23:0] den,
  output logic        done,
  output logic [7:0]  quo
);
  logic [31:0] rem_r;
  logic [31:0] dsh_r;
  logic [7:0]  quo_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd8;
        rem_r  <= num;
        dsh_r  <= {1'b0, den, 7'd0};
        quo_r  <= '0;
      end else if (busy_r) begin
        // restoring step
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          quo_r <= {quo_r[6:0], 1'b1};
        end else begin
          quo_r <= {quo_r[6:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

>>> verif/particle_table_update_tb.sv
// Testbench: drives spawn and tick words into the particle table and checks every result word.
`timescale 1ns / 1ps
module particle_table_update_tb;
  import ptu_pkg::*;

  localparam int NUM_SLOTS  = 64;
  localparam int IDLE_LIMIT = 30000;
  localparam int HOLD_LEN   = 1500;
  localparam int DRAIN_LEN  = 1500;

  // one stimulus row; a typed row also carries the result count read off by hand
  typedef struct {
    in_word_t  w;
    bit        typed;
    int        n_typed;
    out_word_t t;
  } stim_row_t;

  logic clk;
  logic rst_n;
  ptu_in_if  in_ch ();
  ptu_out_if out_ch ();

  particle_table_update #(.MAX_PARTICLES(NUM_SLOTS)) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // shadow particle table
  logic        [31:0] sh_px [NUM_SLOTS];
  logic        [31:0] sh_py [NUM_SLOTS];
  logic        [31:0] sh_vx [NUM_SLOTS];
  logic        [31:0] sh_vy [NUM_SLOTS];
  logic        [31:0] sh_gx [NUM_SLOTS];
  logic        [31:0] sh_gy [NUM_SLOTS];
  logic        [15:0] sh_ang[NUM_SLOTS];
  logic signed [15:0] sh_spn[NUM_SLOTS];
  logic        [23:0] sh_age[NUM_SLOTS];
  logic        [23:0] sh_lim[NUM_SLOTS];
  logic        [23:0] sh_col[NUM_SLOTS];
  int                 sh_live;

  out_word_t particle_q[$];
  stim_row_t stim_q[$];
  stim_row_t sent_q[$];
  stim_row_t dir_tab[$];

  int  err_cnt;
  int  in_cnt;
  int  out_cnt;
  int  drop_cnt;
  int  tick_cnt;
  int  idle_cnt;
  int  press_idx;
  bit  held;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // predicted results of one accepted word, appended to particle_q
  function automatic int update_table(in_word_t w);
    int          wi;
    longint      a;
    longint      d;
    longint      prod;
    longint      s;
    logic [31:0] nvx;
    logic [31:0] nvy;
    out_word_t   o;
    wi = 0;
    d  = longint'(w.delta_time);
    if (w.opcode == OP_SPAWN) begin
      if (sh_live >= NUM_SLOTS) begin
        o = '0;
        o.last = 1'b1;
        o.dropped = 1'b1;
        particle_q = {particle_q, o};
        return 1;
      end
      sh_px[sh_live]  = w.start_x;
      sh_py[sh_live]  = w.start_y;
      sh_vx[sh_live]  = w.start_vx;
      sh_vy[sh_live]  = w.start_vy;
      sh_ang[sh_live] = 16'(int'(w.start_angle) % FULL_TURN);
      sh_spn[sh_live] = w.spin_rate;
      sh_lim[sh_live] = w.life_limit;
      sh_col[sh_live] = w.rgb_color;
      sh_gx[sh_live]  = w.pull_x;
      sh_gy[sh_live]  = w.pull_y;
      sh_age[sh_live] = '0;
      sh_live++;
      return 0;
    end
    // tick: age, cull, integrate, compact
    for (int i = 0; i < sh_live; i++) begin
      a = longint'(sh_age[i]) + d;
      if (a > longint'(AGE_MAX)) a = longint'(AGE_MAX);
      if (a >= longint'(sh_lim[i])) continue;
      nvx = sh_vx[i] + sh_gx[i];
      nvy = sh_vy[i] + sh_gy[i];
      prod = longint'(signed'(nvx)) * d;
      sh_px[wi] = sh_px[i] + 32'(prod >>> 16);
      prod = longint'(signed'(nvy)) * d;
      sh_py[wi] = sh_py[i] + 32'(prod >>> 16);
      s = longint'(sh_ang[i]) + ((longint'(sh_spn[i]) * d) >>> 15)
          + 2 * longint'(FULL_TURN);
      sh_ang[wi] = 16'(s % longint'(FULL_TURN));
      sh_spn[wi] = sh_spn[i];
      sh_lim[wi] = sh_lim[i];
      sh_col[wi] = sh_col[i];
      sh_gx[wi]  = sh_gx[i];
      sh_gy[wi]  = sh_gy[i];
      sh_vx[wi]  = nvx;
      sh_vy[wi]  = nvy;
      sh_age[wi] = 24'(a);
      o.slot       = 6'(wi);
      o.now_x      = sh_px[wi];
      o.now_y      = sh_py[wi];
      o.now_angle  = sh_ang[wi];
      o.alpha      = 8'(255 - (255 * a) / longint'(sh_lim[wi]));
      o.colour_out = sh_col[wi];
      o.last       = 1'b0;
      o.dropped    = 1'b0;
      particle_q = {particle_q, o};
      wi++;
    end
    sh_live = wi;
    if (wi > 0) particle_q[$].last = 1'b1;
    return wi;
  endfunction

  function automatic in_word_t spawn_word(logic [31:0] x, logic [31:0] y, logic [31:0] vx,
                                          logic [31:0] vy, logic [15:0] ang, logic [15:0] spin,
                                          logic [23:0] life, logic [23:0] col,
                                          logic [31:0] gx, logic [31:0] gy);
    in_word_t w;
    w = '0;
    w.opcode = OP_SPAWN;
    w.start_x = x;
    w.start_y = y;
    w.start_vx = vx;
    w.start_vy = vy;
    w.start_angle = ang;
    w.spin_rate = spin;
    w.life_limit = life;
    w.rgb_color = col;
    w.pull_x = gx;
    w.pull_y = gy;
    w.delta_time = 16'($urandom);
    return w;
  endfunction

  // tick words still carry random spawn fields, which the block ignores
  function automatic in_word_t tick_word(logic [15:0] dt);
    in_word_t w;
    w = spawn_word($urandom, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                   24'($urandom), 24'($urandom), $urandom, $urandom);
    w.opcode = OP_TICK;
    w.delta_time = dt;
    return w;
  endfunction

  // random spawn; lives mostly short (long if long_life) so particles die within a few ticks
  function automatic in_word_t rand_spawn(bit long_life);
    logic [23:0] life;
    case ($urandom_range(0, 3))
      0:       life = 24'($urandom);
      1:       life = 24'($urandom_range(0, 16));
      default: life = 24'($urandom_range(1, 400000));
    endcase
    if (long_life) life = 24'($urandom_range(24'h800000, 24'hFFFFFF));
    return spawn_word($urandom, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                      life, 24'($urandom), $urandom, $urandom);
  endfunction

  function automatic stim_row_t plain_row(in_word_t w);
    stim_row_t r;
    r.w = w;
    r.typed = 1'b0;
    r.n_typed = 0;
    r.t = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(in_word_t w, int n, out_word_t t);
    stim_row_t r;
    r = plain_row(w);
    r.typed = 1'b1;
    r.n_typed = n;
    r.t = t;
    return r;
  endfunction

  // input and result monitor
  always @(posedge clk) begin
    stim_row_t r;
    int        n;
    out_word_t e;
    bit        moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        r = sent_q.pop_front();
        in_cnt++;
        if (r.w.opcode == OP_TICK) tick_cnt++;
        n = update_table(r.w);
        if (r.typed) begin
          if (n != r.n_typed) begin
            $display("%0t: result count mismatch: expected %0d, actual %0d",
                     $time, r.n_typed, n);
            err_cnt++;
          end else if (n == 1 && particle_q[$] !== r.t) begin
            $display("%0t: typed result mismatch: expected %h, actual %h",
                     $time, r.t, particle_q[$]);
            err_cnt++;
          end
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        out_cnt++;
        if (particle_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_ch.data);
          err_cnt++;
        end else begin
          e = particle_q.pop_front();
          if (e.dropped) drop_cnt++;
          if (out_ch.data.slot !== e.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, e.slot, out_ch.data.slot);
            err_cnt++;
          end
          if (out_ch.data.now_x !== e.now_x) begin
            $display("%0t: now_x expected %h actual %h", $time, e.now_x, out_ch.data.now_x);
            err_cnt++;
          end
          if (out_ch.data.now_y !== e.now_y) begin
            $display("%0t: now_y expected %h actual %h", $time, e.now_y, out_ch.data.now_y);
            err_cnt++;
          end
          if (out_ch.data.now_angle !== e.now_angle) begin
            $display("%0t: now_angle expected %0d actual %0d", $time, e.now_angle,
                     out_ch.data.now_angle);
            err_cnt++;
          end
          if (out_ch.data.alpha !== e.alpha) begin
            $display("%0t: alpha expected %0d actual %0d", $time, e.alpha, out_ch.data.alpha);
            err_cnt++;
          end
          if (out_ch.data.colour_out !== e.colour_out) begin
            $display("%0t: colour_out expected %h actual %h", $time, e.colour_out,
                     out_ch.data.colour_out);
            err_cnt++;
          end
          if (out_ch.data.last !== e.last) begin
            $display("%0t: last expected %b actual %b", $time, e.last, out_ch.data.last);
            err_cnt++;
          end
          if (out_ch.data.dropped !== e.dropped) begin
            $display("%0t: dropped expected %b actual %b", $time, e.dropped,
                     out_ch.data.dropped);
            err_cnt++;
          end
        end
      end
      idle_cnt <= moved ? 0 : idle_cnt + 1;
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d result words still expected", $time, particle_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (!held && in_cnt >= press_idx) begin
        held = 1'b1;
        gap = HOLD_LEN;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // stimulus build, input driver and end of run
  initial begin
    stim_row_t r;
    out_word_t none;
    int        gap;
    int        rnd;
    int        burst;
    none = '0;
    err_cnt = 0; in_cnt = 0; out_cnt = 0; drop_cnt = 0; tick_cnt = 0; idle_cnt = 0;
    sh_live = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;

    // directed part: empty tick, field extremes, angle wrap, zero life, dt extremes
    dir_tab = {dir_tab, typed_row(tick_word(16'hFFFF), 0, none)};
    dir_tab = {dir_tab, typed_row(spawn_word(32'h7FFFFFFF, 32'h80000000, 32'h80000000,
               32'h7FFFFFFF, 16'd46079, 16'h8000, 24'hFFFFFF, 24'hFFFFFF,
               32'h7FFFFFFF, 32'h80000000), 0, none)};
    dir_tab = {dir_tab, typed_row(spawn_word(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h80000000, 16'hFFFF, 16'h7FFF, 24'h000001, 24'h000000,
               32'h80000000, 32'h7FFFFFFF), 0, none)};
    dir_tab = {dir_tab, plain_row(spawn_word(0, 0, 0, 0, 16'd46080, 16'd0, 24'h000000,
               24'h123456, 0, 0))};
    dir_tab = {dir_tab, plain_row(spawn_word(32'h100, 32'hFFFFFF00, 32'h1000, 32'hFFFFF000,
               16'd0, 16'h0040, 24'h030000, 24'hABCDEF, 32'h10, 32'hFFFFFFF0))};
    dir_tab = {dir_tab, plain_row(tick_word(16'h0000))};
    dir_tab = {dir_tab, plain_row(tick_word(16'h0001))};
    dir_tab = {dir_tab, plain_row(tick_word(16'hFFFF))};
    dir_tab = {dir_tab, plain_row(tick_word(16'h8000))};
    dir_tab = {dir_tab, plain_row(spawn_word(32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF, 32'h1,
               16'd1, 16'hFFFF, 24'h000002, 24'h00FF00, 32'hFFFFFFFF, 32'h1))};
    dir_tab = {dir_tab, plain_row(tick_word(16'h0001))};
    dir_tab = {dir_tab, plain_row(tick_word(16'hFFFF))};
    dir_tab = {dir_tab, plain_row(tick_word(16'hFFFF))};
    foreach (dir_tab[i]) stim_q = {stim_q, dir_tab[i]};

    // long hold-off on the result side while a table of long-lived particles ticks
    press_idx = stim_q.size();
    for (int i = 0; i < 40; i++) stim_q = {stim_q, plain_row(rand_spawn(1'b1))};
    for (int i = 0; i < 3; i++) stim_q = {stim_q, plain_row(tick_word(16'($urandom)))};

    // overfill so that spawns get dropped
    for (int i = 0; i < 28; i++) stim_q = {stim_q, plain_row(rand_spawn(1'b1))};
    stim_q = {stim_q, plain_row(tick_word(16'($urandom)))};
    for (int i = 0; i < 4; i++) stim_q = {stim_q, plain_row(tick_word(16'hFFFF))};

    // random bursts of spawns followed by a few ticks
    rnd = 0;
    while (rnd < 30) begin
      burst = $urandom_range(0, 6);
      for (int i = 0; i < burst; i++) stim_q = {stim_q, plain_row(rand_spawn(1'b0))};
      burst = $urandom_range(1, 3);
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(0, 4) == 0)
          stim_q = {stim_q, plain_row(tick_word(16'($urandom_range(0, 3))))};
        else
          stim_q = {stim_q, plain_row(tick_word(16'($urandom)))};
      end
      rnd = stim_q.size() - press_idx - 76;
    end

    // reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // input driver
    while (stim_q.size() > 0) begin
      r = stim_q.pop_front();
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      sent_q = {sent_q, r};
      in_ch.valid <= 1'b1;
      in_ch.data <= r.w;
      do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    end
    in_ch.valid <= 1'b0;

    // drain, then allow for trailing words
    while (particle_q.size() > 0) @(posedge clk);
    repeat (DRAIN_LEN) @(posedge clk);

    $display("Run covered %0d input words (%0d ticks) and %0d result words, %0d drops.",
             in_cnt, tick_cnt, out_cnt, drop_cnt);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
